[rtl/cmu_pkg.sv]
// Shared widths, codes and count-class helpers for the coverage map update block.
package cmu_pkg;

  // Field widths of the stream items
  localparam int INDEX_W     = 16;
  localparam int COUNT_W     = 8;
  localparam int CLASS_W     = 8;
  localparam int VERDICT_W   = 2;
  localparam int HASH_W      = 64;
  localparam int ENTRY_CNT_W = 17;
  localparam int BIT_CNT_W   = 20;
  localparam int POP_W       = 4;

  // Default map depth
  localparam int MAP_ENTRIES_DEF = 1 << 16;

  // Packed widths of the stream buses
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 104;

  // Verdict codes
  localparam logic [VERDICT_W-1:0] VERDICT_NONE  = 2'd0;
  localparam logic [VERDICT_W-1:0] VERDICT_CLASS = 2'd1;
  localparam logic [VERDICT_W-1:0] VERDICT_EDGE  = 2'd2;
  localparam logic [VERDICT_W-1:0] VERDICT_BAD   = 2'd3;

  // Map a raw hit count onto its one-hot logarithmic class
  function automatic logic [CLASS_W-1:0] count_class(input logic [COUNT_W-1:0] c);
    logic [CLASS_W-1:0] r;
    case (c) inside
      8'd0:             r = 8'h00;
      8'd1:             r = 8'h01;
      8'd2:             r = 8'h02;
      8'd3:             r = 8'h04;
      [8'd4:8'd7]:      r = 8'h08;
      [8'd8:8'd15]:     r = 8'h10;
      [8'd16:8'd31]:    r = 8'h20;
      [8'd32:8'd127]:   r = 8'h40;
      default:          r = 8'h80;
    endcase
    return r;
  endfunction

  // Number of set bits in a class byte
  function automatic logic [POP_W-1:0] class_ones(input logic [CLASS_W-1:0] v);
    logic [POP_W-1:0] n;
    n = '0;
    for (int i = 0; i < CLASS_W; i++) begin
      n = n + POP_W'(v[i]);
    end
    return n;
  endfunction

endpackage

[rtl/cmu_map_ram.sv]
// Coverage map storage: one write port, one read port with registered read data.
module cmu_map_ram
  import cmu_pkg::*;
#(
  parameter int DEPTH  = MAP_ENTRIES_DEF,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic               clk,
  input  logic               wen,
  input  logic [ADDR_W-1:0]  waddr,
  input  logic [CLASS_W-1:0] wdata,
  input  logic               ren,
  input  logic [ADDR_W-1:0]  raddr,
  output logic [CLASS_W-1:0] rdata
);

  logic [CLASS_W-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, old data on a same-edge write
  always_ff @(posedge clk) begin
    if (ren) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/cmu_clear.sv]
// Clearing sweep that zeroes every map entry after reset, one entry a cycle.
module cmu_clear
  import cmu_pkg::*;
#(
  parameter int DEPTH  = MAP_ENTRIES_DEF,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              rst,
  output logic              busy,
  output logic [ADDR_W-1:0] addr
);

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

  // Advance the sweep address and drop busy after the last entry
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
      addr <= '0;
    end else if (busy) begin
      if (addr == LAST_ADDR) begin
        busy <= 1'b0;
      end
      addr <= addr + 1'b1;
    end
  end

endmodule

[rtl/coverage_map_update.sv]
// Top level of the coverage map update block: read stage, update stage and result register.
//
// Each transfer carries one map entry of a run; its count class is ORed into the stored
// coverage map by a read-modify-write on a single-port-write memory with one cycle of read
// latency. An item passes from the read stage to the update stage, and a new item is taken
// every cycle while the input is not stalled; a back-to-back write to the same entry is
// forwarded from the update stage. A run-end item produces one result that sits in an
// output register; apart from the clearing pass, input stalls only when a second run-end
// item reaches the update stage while the previous result has not been taken. After reset
// a clearing pass zeroes the map, one entry a cycle, during which no item is accepted;
// write the edge_only register only while no item is in flight.
module coverage_map_update
  import cmu_pkg::*;
#(
  parameter int MAP_ENTRIES = MAP_ENTRIES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // edge_only register write
  input  logic                  cfg_wen,
  input  logic                  cfg_wdata,
  // input stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // entry_index[15:0], hit_count[23:16]
  input  logic                  s_axis_tlast,   // run_end
  // result stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata    // verdict[1:0], map_hash[65:2],
                                                // covered_entries[82:66],
                                                // covered_bits[102:83], zero[103]
);

  localparam int ADDR_W = $clog2(MAP_ENTRIES);

  // Configuration
  logic edge_only;

  // Clearing sweep
  logic              clr_busy;
  logic [ADDR_W-1:0] clr_addr;

  // Input decode
  logic              in_xfer;
  logic [31:0]       in_index_ext;
  logic              in_range;
  logic [ADDR_W-1:0] in_addr;

  // Update stage registers
  logic               s2_valid;
  logic               s2_last;
  logic               s2_in_range;
  logic [ADDR_W-1:0]  s2_addr;
  logic [COUNT_W-1:0] s2_cnt;
  logic [2:0]         s2_lane;
  logic               s2_fwd_hit;
  logic [CLASS_W-1:0] s2_fwd_data;

  // Update stage logic
  logic               s2_go;
  logic               s2_wr;
  logic [CLASS_W-1:0] rd_data;
  logic [CLASS_W-1:0] old_class;
  logic [CLASS_W-1:0] upd_class;
  logic [CLASS_W-1:0] new_bits;
  logic               changed;
  logic               was_zero;

  // Run and map tracking
  logic [VERDICT_W-1:0]   run_verdict;
  logic [HASH_W-1:0]      run_hash;
  logic [ENTRY_CNT_W-1:0] entry_count;
  logic [BIT_CNT_W-1:0]   bit_count;
  logic [VERDICT_W-1:0]   verdict_next;
  logic [VERDICT_W-1:0]   verdict_report;
  logic [HASH_W-1:0]      hash_next;
  logic [ENTRY_CNT_W-1:0] entry_count_next;
  logic [BIT_CNT_W-1:0]   bit_count_next;

  // Result register
  logic                   out_valid;
  logic [VERDICT_W-1:0]   out_verdict;
  logic [HASH_W-1:0]      out_hash;
  logic [ENTRY_CNT_W-1:0] out_entries;
  logic [BIT_CNT_W-1:0]   out_bits;

  // Memory port signals
  logic              mem_wen;
  logic [ADDR_W-1:0] mem_waddr;
  logic [CLASS_W-1:0] mem_wdata;

  // Hold the edge_only register
  always_ff @(posedge clk) begin
    if (rst) begin
      edge_only <= 1'b0;
    end else if (cfg_wen) begin
      edge_only <= cfg_wdata;
    end
  end

  cmu_clear #(
    .DEPTH  (MAP_ENTRIES),
    .ADDR_W (ADDR_W)
  ) u_clear (
    .clk  (clk),
    .rst  (rst),
    .busy (clr_busy),
    .addr (clr_addr)
  );

  // Decode the input transfer
  assign in_index_ext  = 32'(s_axis_tdata[INDEX_W-1:0]);
  assign in_range      = in_index_ext < 32'(MAP_ENTRIES);
  assign in_addr       = in_index_ext[ADDR_W-1:0];
  assign s2_go         = s2_valid && !(s2_last && out_valid && !m_axis_tready);
  assign s_axis_tready = !clr_busy && (!s2_valid || s2_go);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  // Select sweep or update write
  always_comb begin
    if (clr_busy) begin
      mem_wen   = 1'b1;
      mem_waddr = clr_addr;
      mem_wdata = '0;
    end else begin
      mem_wen   = s2_wr;
      mem_waddr = s2_addr;
      mem_wdata = upd_class;
    end
  end

  cmu_map_ram #(
    .DEPTH  (MAP_ENTRIES),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk   (clk),
    .wen   (mem_wen),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .ren   (in_xfer),
    .raddr (in_addr),
    .rdata (rd_data)
  );

  // Advance the item into the update stage, noting a write to the same entry
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (in_xfer) begin
      s2_valid <= 1'b1;
    end else if (s2_go) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s2_last     <= s_axis_tlast;
      s2_in_range <= in_range;
      s2_addr     <= in_addr;
      s2_cnt      <= s_axis_tdata[INDEX_W +: COUNT_W];
      s2_lane     <= s_axis_tdata[2:0];
      s2_fwd_hit  <= s2_wr && (s2_addr == in_addr);
      s2_fwd_data <= upd_class;
    end
  end

  // Merge the class into the stored entry
  assign old_class = s2_fwd_hit ? s2_fwd_data : rd_data;
  assign upd_class = old_class | count_class(s2_cnt);
  assign new_bits  = upd_class & ~old_class;
  assign changed   = s2_in_range && (new_bits != '0);
  assign was_zero  = old_class == '0;
  assign s2_wr     = s2_go && s2_in_range;

  // Work out the run verdict, hash and map counts including this item
  always_comb begin
    verdict_next = run_verdict;
    if (changed) begin
      if (was_zero) begin
        verdict_next = VERDICT_EDGE;
      end else if (run_verdict == VERDICT_NONE) begin
        verdict_next = VERDICT_CLASS;
      end
    end
    verdict_report = (edge_only && verdict_next != VERDICT_EDGE) ? VERDICT_NONE
                                                                  : verdict_next;
    hash_next = run_hash;
    if (s2_in_range) begin
      hash_next = run_hash ^ (HASH_W'(s2_cnt) << {s2_lane, 3'b000});
    end
    entry_count_next = entry_count + ENTRY_CNT_W'(changed && was_zero);
    bit_count_next   = bit_count + BIT_CNT_W'(class_ones(changed ? new_bits : '0));
  end

  // Update run state, restart it after the run-end item
  always_ff @(posedge clk) begin
    if (rst) begin
      run_verdict <= VERDICT_NONE;
      run_hash    <= '0;
      entry_count <= '0;
      bit_count   <= '0;
    end else if (s2_go) begin
      entry_count <= entry_count_next;
      bit_count   <= bit_count_next;
      if (s2_last) begin
        run_verdict <= VERDICT_NONE;
        run_hash    <= '0;
      end else begin
        run_verdict <= verdict_next;
        run_hash    <= hash_next;
      end
    end
  end

  // Hold the result until the transfer completes
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_go && s2_last) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_go && s2_last) begin
      out_verdict <= verdict_report;
      out_hash    <= hash_next;
      out_entries <= entry_count_next;
      out_bits    <= bit_count_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {1'b0, out_bits, out_entries, out_hash, out_verdict};

endmodule

[rtl/cmu_checker.sv]
// Port-level checker for the coverage map update block, with its bind statement.
module cmu_checker
  import cmu_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_axis_tready,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata
);

  // Input held off while the map is being cleared after reset
  a_no_accept_after_reset: assert property (@(posedge clk) rst |=> !s_axis_tready)
    else $error("input ready straight after reset");

  // No result straight after reset
  a_no_result_after_reset: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid straight after reset");

  // A stalled result holds
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // The verdict is never the unused code
  a_verdict_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[1:0] != VERDICT_BAD)
    else $error("unused verdict code");

  // Every covered entry holds at least one class bit
  a_bits_cover_entries: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[102:83] >= {3'b000, m_axis_tdata[82:66]})
    else $error("fewer class bits than covered entries");

endmodule

bind coverage_map_update cmu_checker u_cmu_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

[dv/coverage_map_update_tb.sv]
// Self-checking testbench for the coverage map update block: streamed map entries, run results.
module coverage_map_update_tb;
  import cmu_pkg::*;

  localparam int POOL_SIZE    = 48;
  localparam int RANDOM_ITEMS = 1350;
  localparam int SETTLE       = 8;

  typedef struct {
    logic [INDEX_W-1:0] index;
    logic [COUNT_W-1:0] hit_count;
    logic               run_end;
  } map_entry_t;

  typedef struct {
    logic [VERDICT_W-1:0]   verdict;
    logic [HASH_W-1:0]      hash;
    logic [ENTRY_CNT_W-1:0] entries;
    logic [BIT_CNT_W-1:0]   bits;
  } run_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_wen = 1'b0;
  logic                  cfg_wdata = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;    // entry_index[15:0], hit_count[23:16]
  logic                  s_axis_tlast = 1'b0;  // run_end
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;         // verdict[1:0], map_hash[65:2],
                                               // covered_entries[82:66], covered_bits[102:83]

  coverage_map_update u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wen      (cfg_wen),
    .cfg_wdata    (cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #1 clk = ~clk;

  // Predicted copy of the block state
  logic [CLASS_W-1:0]     cov_map [0:MAP_ENTRIES_DEF-1];
  logic [VERDICT_W-1:0]   run_verdict_q = VERDICT_NONE;
  logic [HASH_W-1:0]      run_hash_q = '0;
  logic [ENTRY_CNT_W-1:0] covered_entries_q = '0;
  logic [BIT_CNT_W-1:0]   covered_bits_q = '0;
  logic                   edge_only_q = 1'b0;

  map_entry_t  pending_entries [$];
  run_result_t expected_runs [$];
  map_entry_t  tx_entry;
  map_entry_t  rx_entry;
  run_result_t got_run;
  run_result_t want_run;

  bit tx_gaps   = 1'b0;
  bit rx_stalls = 1'b0;
  int tx_hold   = 0;
  int rx_hold   = 0;
  int errors    = 0;
  int items_accepted = 0;
  int runs_checked   = 0;
  int verdict_seen [0:3] = '{0, 0, 0, 0};

  // Pick an idle length: mostly short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 8);
    return $urandom_range(20, 40);
  endfunction

  // Merge one accepted entry into the predicted map; close the run on its last entry
  task automatic merge_hit_entry(input map_entry_t e);
    logic [CLASS_W-1:0] old_cls;
    logic [CLASS_W-1:0] cls;
    logic [CLASS_W-1:0] new_cls;
    run_result_t        res;
    if (e.hit_count == 0)        cls = 8'h00;
    else if (e.hit_count == 1)   cls = 8'h01;
    else if (e.hit_count == 2)   cls = 8'h02;
    else if (e.hit_count == 3)   cls = 8'h04;
    else if (e.hit_count <= 7)   cls = 8'h08;
    else if (e.hit_count <= 15)  cls = 8'h10;
    else if (e.hit_count <= 31)  cls = 8'h20;
    else if (e.hit_count <= 127) cls = 8'h40;
    else                         cls = 8'h80;
    old_cls = cov_map[e.index];
    new_cls = old_cls | cls;
    run_hash_q = run_hash_q ^ (HASH_W'(e.hit_count) << (8 * e.index[2:0]));
    if (new_cls != old_cls) begin
      if (old_cls == '0) begin
        run_verdict_q = VERDICT_EDGE;
        covered_entries_q = covered_entries_q + 1'b1;
      end else if (run_verdict_q == VERDICT_NONE) begin
        run_verdict_q = VERDICT_CLASS;
      end
      covered_bits_q = covered_bits_q + BIT_CNT_W'($countones(new_cls))
                       - BIT_CNT_W'($countones(old_cls));
      cov_map[e.index] = new_cls;
    end
    if (e.run_end) begin
      res.verdict = (edge_only_q && run_verdict_q != VERDICT_EDGE) ? VERDICT_NONE
                                                                   : run_verdict_q;
      res.hash    = run_hash_q;
      res.entries = covered_entries_q;
      res.bits    = covered_bits_q;
      expected_runs = {expected_runs, res};
      run_verdict_q = VERDICT_NONE;
      run_hash_q = '0;
    end
  endtask

  task automatic check_field(input string name, input logic [63:0] want_v,
                             input logic [63:0] got_v);
    if (want_v !== got_v) begin
      errors++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want_v, got_v);
    end
  endtask

  // Driver: present pending entries, hold each until its transfer
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      tx_hold <= 0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (tx_hold != 0) begin
        tx_hold <= tx_hold - 1;
        s_axis_tvalid <= 1'b0;
      end else if (pending_entries.size() != 0) begin
        tx_entry = pending_entries.pop_front();
        s_axis_tdata  <= {tx_entry.hit_count, tx_entry.index};
        s_axis_tlast  <= tx_entry.run_end;
        s_axis_tvalid <= 1'b1;
        if (tx_gaps && $urandom_range(0, 2) == 0) tx_hold <= pick_gap();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Result sink: stall at random
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      rx_hold <= 0;
    end else if (rx_hold != 0) begin
      rx_hold <= rx_hold - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      if (rx_stalls && $urandom_range(0, 3) == 0) rx_hold <= pick_gap();
    end
  end

  // Monitor: check result transfers, then predict from input transfers
  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_run.verdict = m_axis_tdata[1:0];
        got_run.hash    = m_axis_tdata[65:2];
        got_run.entries = m_axis_tdata[82:66];
        got_run.bits    = m_axis_tdata[102:83];
        if (expected_runs.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, actual verdict %0d hash 0x%0h",
                   $time, got_run.verdict, got_run.hash);
        end else begin
          want_run = expected_runs.pop_front();
          check_field("verdict", 64'(want_run.verdict), 64'(got_run.verdict));
          check_field("map_hash", want_run.hash, got_run.hash);
          check_field("covered_entries", 64'(want_run.entries), 64'(got_run.entries));
          check_field("covered_bits", 64'(want_run.bits), 64'(got_run.bits));
          runs_checked++;
          verdict_seen[got_run.verdict]++;
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        items_accepted++;
        rx_entry.index     = s_axis_tdata[INDEX_W-1:0];
        rx_entry.hit_count = s_axis_tdata[INDEX_W +: COUNT_W];
        rx_entry.run_end   = s_axis_tlast;
        merge_hit_entry(rx_entry);
      end
    end
  end

  task automatic queue_entry(input int idx, input int cnt, input bit last);
    map_entry_t e;
    e.index     = INDEX_W'(idx);
    e.hit_count = COUNT_W'(cnt);
    e.run_end   = last;
    pending_entries = {pending_entries, e};
  endtask

  // Hold the sender until all results are in and the pipeline has settled
  task automatic wait_idle();
    while (pending_entries.size() != 0 || s_axis_tvalid || expected_runs.size() != 0)
      @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_edge_only(input bit v);
    @(posedge clk);
    cfg_wen   <= 1'b1;
    cfg_wdata <= v;
    edge_only_q = v;
    @(posedge clk);
    cfg_wen <= 1'b0;
    @(negedge clk);
  endtask

  // Stimulus sequence
  initial begin : stimulus
    int         random_items;
    int         phase_items;
    int         run_len;
    int         phase;
    logic [15:0] pool_base;
    map_entry_t e;
    random_items = 0;
    phase = 0;
    for (int i = 0; i < MAP_ENTRIES_DEF; i++) cov_map[i] = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    write_edge_only(1'b0);

    // Zero count alone, then every count class on fresh edges
    queue_entry(0, 0, 1);
    queue_entry(0, 1, 0);
    queue_entry(1, 2, 0);
    queue_entry(2, 3, 0);
    queue_entry(3, 4, 0);
    queue_entry(4, 7, 0);
    queue_entry(5, 8, 0);
    queue_entry(6, 15, 0);
    queue_entry(7, 16, 1);
    queue_entry(8, 31, 0);
    queue_entry(9, 32, 0);
    queue_entry(10, 127, 0);
    queue_entry(11, 128, 0);
    queue_entry(65535, 255, 1);
    // Nothing new, then a new class only
    queue_entry(0, 1, 1);
    queue_entry(0, 2, 1);
    // Same index twice cancels in the hash
    queue_entry(12, 5, 0);
    queue_entry(12, 5, 1);
    // Class first, then an edge: verdict only rises
    queue_entry(1, 200, 0);
    queue_entry(20, 1, 1);
    wait_idle();

    // Edge-only mode: a class-only run reports nothing new
    write_edge_only(1'b1);
    queue_entry(0, 4, 1);
    queue_entry(30, 9, 1);
    queue_entry(0, 200, 0);
    queue_entry(31, 1, 1);
    wait_idle();

    // Random runs over a small pool of entries per phase, with stray full-range indexes
    while (random_items < RANDOM_ITEMS) begin
      write_edge_only(phase[0]);
      tx_gaps   = ($urandom_range(0, 3) != 0);
      rx_stalls = ($urandom_range(0, 3) != 0);
      pool_base = 16'($urandom);
      phase_items = 0;
      while (phase_items < 200 && random_items < RANDOM_ITEMS) begin
        run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
        for (int k = 0; k < run_len; k++) begin
          e.index = ($urandom_range(0, 9) < 8) ? pool_base + 16'($urandom_range(0, POOL_SIZE - 1))
                                               : 16'($urandom);
          case ($urandom_range(0, 8))
            0:       e.hit_count = 8'd0;
            1:       e.hit_count = 8'd1;
            2:       e.hit_count = 8'd2;
            3:       e.hit_count = 8'd3;
            4:       e.hit_count = 8'($urandom_range(4, 7));
            5:       e.hit_count = 8'($urandom_range(8, 15));
            6:       e.hit_count = 8'($urandom_range(16, 31));
            7:       e.hit_count = 8'($urandom_range(32, 127));
            default: e.hit_count = 8'($urandom_range(128, 255));
          endcase
          e.run_end = (k == run_len - 1);
          pending_entries = {pending_entries, e};
        end
        phase_items += run_len;
        random_items += run_len;
      end
      wait_idle();
      phase++;
    end

    $display("Summary: %0d entries in %0d runs over %0d phases, edge_only at 0 and 1",
             items_accepted, runs_checked, phase + 2);
    $display("Summary: verdicts none/class/edge %0d/%0d/%0d, final map %0d entries %0d bits",
             verdict_seen[0], verdict_seen[1], verdict_seen[2],
             covered_entries_q, covered_bits_q);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog: ends a hung run
  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

endmodule

[coverage_map_update.f]
rtl/cmu_pkg.sv
rtl/cmu_map_ram.sv
rtl/cmu_clear.sv
rtl/coverage_map_update.sv
rtl/cmu_checker.sv
dv/coverage_map_update_tb.sv
